>>> rtl/bfpa_pkg.sv
// Package for the best-fit partition allocator: types and constants.
// No dependencies.
package bfpa_pkg;
    localparam int unsigned FIELD_BITS = 16;
    localparam int unsigned OWNER_BITS = 8;

    typedef enum logic [0:0] {
        CMD_ADD   = 1'b0,
        CMD_ALLOC = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_FULL      = 2'd2,
        ST_ADDED     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        EX_IDLE   = 2'd0,
        EX_SEARCH = 2'd1,
        EX_UPDATE = 2'd2,
        EX_EMIT   = 2'd3
    } t_ex_state;

    typedef struct packed {
        t_cmd                    cmd;
        logic [FIELD_BITS-1:0]   req_size;
        logic [FIELD_BITS-1:0]   part_start;
        logic [OWNER_BITS-1:0]   owner_id;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic [OWNER_BITS-1:0]   owner_tag;
        logic [FIELD_BITS-1:0]   block_start;
        logic [FIELD_BITS-1:0]   block_end;
        logic [FIELD_BITS-1:0]   block_size;
        logic [FIELD_BITS-1:0]   alloc_number;
    } t_rsp;
endpackage

>>> rtl/bfpa_if.sv
// Valid/ready channel interfaces carrying a request, response or config beat.
// Depends on bfpa_pkg.
interface bfpa_req_if;
    logic            valid;
    logic            ready;
    bfpa_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bfpa_rsp_if;
    logic            valid;
    logic            ready;
    bfpa_pkg::t_rsp  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bfpa_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bfpa_pkg::FIELD_BITS-1:0]    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/bfpa_front.sv
// Front end: accepts request beats into a two-entry queue.
// Depends on bfpa_pkg.
module bfpa_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bfpa_pkg::t_req  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output bfpa_pkg::t_req  o_data
);
    bfpa_pkg::t_req r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

>>> rtl/bfpa_back.sv
// Back end: free table, best-fit search and sorted insert by shifting.
// Depends on bfpa_pkg.
module bfpa_back #(
    parameter int unsigned FREE_ENTRIES = 16,
    parameter int unsigned ADDR_BITS    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  bfpa_pkg::t_req                    i_data,
    input  logic [bfpa_pkg::FIELD_BITS-1:0]   i_min_fragment,
    output logic                              o_valid,
    input  logic                              i_ready,
    output bfpa_pkg::t_rsp                    o_data
);
    localparam int unsigned IW = $clog2(FREE_ENTRIES);
    localparam int unsigned CW = $clog2(FREE_ENTRIES + 1);
    localparam int unsigned FB = bfpa_pkg::FIELD_BITS;

    logic [ADDR_BITS-1:0] r_starts [FREE_ENTRIES];
    logic [FB-1:0]        r_sizes  [FREE_ENTRIES];
    logic [CW-1:0]        r_count;
    logic [FB-1:0]        r_acnt;

    bfpa_pkg::t_ex_state  r_st, n_st;
    bfpa_pkg::t_req       r_req;
    bfpa_pkg::t_rsp       r_rsp;
    logic                 r_ovalid;

    // update operation latched in SEARCH
    logic                 r_do_rm, r_do_ins;
    logic [IW-1:0]        r_rm_idx;
    logic [ADDR_BITS-1:0] r_ins_start;
    logic [FB-1:0]        r_ins_size;

    logic                 w_take;
    logic [FREE_ENTRIES-1:0] w_ge;
    logic [IW-1:0]        w_idx;
    logic                 w_found;
    logic [ADDR_BITS-1:0] w_fs;
    logic [FB-1:0]        w_fz, w_left, w_bsize;
    logic [ADDR_BITS-1:0] w_bend, w_rstart;
    logic                 w_full;

    // insert position and shifted table
    logic [CW-1:0]        w_cnt_rm;
    logic [FREE_ENTRIES-1:0] w_lt;
    logic [ADDR_BITS-1:0] w_st_rm [FREE_ENTRIES];
    logic [FB-1:0]        w_sz_rm [FREE_ENTRIES];

    assign o_valid = r_ovalid;
    assign o_data  = r_rsp;
    // take a new request only once the response register is free by the next edge
    assign o_ready = (r_st == bfpa_pkg::EX_IDLE) && (!r_ovalid || i_ready);
    assign w_take  = i_valid && o_ready;
    assign w_full  = (r_count >= CW'(FREE_ENTRIES));

    always_comb begin
        for (int i = 0; i < FREE_ENTRIES; i++) begin
            w_ge[i] = (CW'(i) < r_count) && (r_sizes[i] >= r_req.req_size);
        end
    end

    // first set bit of the compare vector
    always_comb begin
        w_idx   = '0;
        w_found = 1'b0;
        for (int i = FREE_ENTRIES - 1; i >= 0; i--) begin
            if (w_ge[i]) begin
                w_idx   = IW'(i);
                w_found = 1'b1;
            end
        end
        w_fs     = r_starts[w_idx];
        w_fz     = r_sizes[w_idx];
        w_left   = w_fz - r_req.req_size;
        w_bsize  = (w_left <= i_min_fragment) ? w_fz : r_req.req_size;
        w_bend   = w_fs + ADDR_BITS'(w_bsize) - ADDR_BITS'(1);
        w_rstart = w_fs + ADDR_BITS'(r_req.req_size);
    end

    // table after optional removal, then insert position
    always_comb begin
        for (int i = 0; i < FREE_ENTRIES; i++) begin
            if (r_do_rm && IW'(i) >= r_rm_idx && i + 1 < FREE_ENTRIES) begin
                w_st_rm[i] = r_starts[i + 1];
                w_sz_rm[i] = r_sizes[i + 1];
            end else begin
                w_st_rm[i] = r_starts[i];
                w_sz_rm[i] = r_sizes[i];
            end
        end
        w_cnt_rm = r_do_rm ? r_count - CW'(1) : r_count;
        for (int i = 0; i < FREE_ENTRIES; i++) begin
            w_lt[i] = (CW'(i) < w_cnt_rm) && (w_sz_rm[i] < r_ins_size);
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            bfpa_pkg::EX_IDLE:   if (w_take) n_st = bfpa_pkg::EX_SEARCH;
            bfpa_pkg::EX_SEARCH: n_st = bfpa_pkg::EX_UPDATE;
            bfpa_pkg::EX_UPDATE: n_st = bfpa_pkg::EX_EMIT;
            bfpa_pkg::EX_EMIT:   n_st = bfpa_pkg::EX_IDLE;
            default:             n_st = bfpa_pkg::EX_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= bfpa_pkg::EX_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_acnt   <= '0;
            r_ovalid <= 1'b0;
            r_do_rm  <= 1'b0;
            r_do_ins <= 1'b0;
        end else begin
            if (r_st == bfpa_pkg::EX_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                bfpa_pkg::EX_IDLE: begin
                    if (w_take) r_req <= i_data;
                end
                bfpa_pkg::EX_SEARCH: begin
                    r_rsp.owner_tag    <= r_req.owner_id;
                    r_rsp.block_start  <= '0;
                    r_rsp.block_end    <= '0;
                    r_rsp.block_size   <= '0;
                    r_rsp.alloc_number <= '0;
                    r_do_rm  <= 1'b0;
                    r_do_ins <= 1'b0;
                    r_rm_idx <= w_idx;
                    if (r_req.cmd == bfpa_pkg::CMD_ADD) begin
                        r_ins_start <= ADDR_BITS'(r_req.part_start);
                        r_ins_size  <= r_req.req_size;
                        if (w_full) begin
                            r_rsp.status <= bfpa_pkg::ST_FULL;
                        end else begin
                            r_rsp.status <= bfpa_pkg::ST_ADDED;
                            r_do_ins <= (r_req.req_size != '0);
                        end
                    end else if (r_req.req_size == '0 || !w_found) begin
                        r_rsp.status <= bfpa_pkg::ST_NO_FIT;
                    end else begin
                        r_rsp.status      <= bfpa_pkg::ST_ALLOCATED;
                        r_rsp.block_start <= FB'(w_fs);
                        r_rsp.block_end   <= FB'(w_bend);
                        r_rsp.block_size  <= w_bsize;
                        r_rsp.alloc_number <= r_acnt + FB'(1);
                        r_acnt   <= r_acnt + FB'(1);
                        r_do_rm  <= 1'b1;
                        r_do_ins <= (w_left > i_min_fragment);
                        r_ins_start <= w_rstart;
                        r_ins_size  <= w_left;
                    end
                end
                bfpa_pkg::EX_UPDATE: begin
                    r_count <= w_cnt_rm + CW'(r_do_ins);
                    for (int i = 0; i < FREE_ENTRIES; i++) begin
                        if (r_do_rm || r_do_ins) begin
                            if (!r_do_ins || w_lt[i]) begin
                                r_starts[i] <= w_st_rm[i];
                                r_sizes[i]  <= w_sz_rm[i];
                            end else if (i == 0 || w_lt[i - 1]) begin
                                r_starts[i] <= r_ins_start;
                                r_sizes[i]  <= r_ins_size;
                            end else begin
                                r_starts[i] <= w_st_rm[i - 1];
                                r_sizes[i]  <= w_sz_rm[i - 1];
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

>>> rtl/best_fit_partition_allocator_core.sv
// Top level of the best-fit partition allocator.
// Depends on bfpa_pkg, bfpa_if, bfpa_front and bfpa_back.
//
// Usage:
//   i_req  : request beats (cmd, req_size, part_start, owner_id).
//            cmd add inserts a free partition in size order; cmd alloc
//            grants the smallest fitting block, splitting off the rest
//            when the leftover exceeds min_fragment.
//   o_rsp  : one response beat per request, in order.
//   i_cfg  : writes min_fragment; write only while the block is idle.
// Timing: a request passes a two-beat input queue, then the execution
//   engine works in four steps (capture, parallel size compare with
//   best-fit pick and update decision, shift-insert into the register
//   table, response load). The sequential engine works one request at a
//   time and takes the next only once the response register is free.
// Reset: empties the free table count, clears the allocation number and
//   sets min_fragment to zero; no clearing pass is needed.
// Stall: a held response blocks the engine; the queue keeps absorbing
//   up to two request beats meanwhile.
module best_fit_partition_allocator_core #(
    parameter int unsigned FREE_ENTRIES = 16,
    parameter int unsigned ADDR_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfpa_req_if.sink    i_req,
    bfpa_rsp_if.source  o_rsp,
    bfpa_cfg_if.sink    i_cfg
);
    logic [bfpa_pkg::FIELD_BITS-1:0] r_min_fragment;
    logic           w_q_valid, w_q_ready;
    bfpa_pkg::t_req w_q_data;

    // config always accepted; hold register value otherwise
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_fragment <= '0;
        end else if (i_cfg.valid) begin
            r_min_fragment <= i_cfg.data;
        end
    end

    bfpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_data  (i_req.data),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_data)
    );

    bfpa_back #(
        .FREE_ENTRIES (FREE_ENTRIES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_q_valid),
        .o_ready        (w_q_ready),
        .i_data         (w_q_data),
        .i_min_fragment (r_min_fragment),
        .o_valid        (o_rsp.valid),
        .i_ready        (o_rsp.ready),
        .o_data         (o_rsp.data)
    );

`ifndef ASSERT_OFF
    // a non-grant never carries a block size
    a_nofit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.status != bfpa_pkg::ST_ALLOCATED
        |-> o_rsp.data.block_size == '0)
        else $error("non-grant response with nonzero size");
    // a grant never has zero size
    a_grant_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.status == bfpa_pkg::ST_ALLOCATED
        |-> o_rsp.data.block_size != '0)
        else $error("grant of zero size");
    // a stalled response does not change
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.data))
        else $error("response changed while stalled");
`endif
endmodule
